### rtl/core/cfv_pkg.sv
// Shared types, constants and CRC function for the frame validator.
package cfv_pkg;

  // Receive buffer size in bytes; the length count saturates here
  localparam int BUFFER_BYTES = 64;
  localparam int CNT_W        = $clog2(BUFFER_BYTES + 1);
  localparam int SZ_W         = CNT_W + 1;

  // CRC-16/CCITT-FALSE
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Frame type codes carried in byte 0
  localparam logic [7:0] TYPE_CONTINUOUS = 8'h01;
  localparam logic [7:0] TYPE_TIMED      = 8'h02;
  localparam logic [7:0] TYPE_ACK        = 8'h03;

  // Frame sizes per type
  localparam logic [SZ_W-1:0] SIZE_CONTINUOUS = SZ_W'(27);
  localparam logic [SZ_W-1:0] SIZE_TIMED      = SZ_W'(39);
  localparam logic [SZ_W-1:0] SIZE_ACK        = SZ_W'(8);
  localparam logic [SZ_W-1:0] SIZE_NONE       = '0;

  typedef enum logic [1:0] {
    VERDICT_VALID        = 2'd0,
    VERDICT_TOO_SHORT    = 2'd1,
    VERDICT_CRC_MISMATCH = 2'd2,
    VERDICT_UNKNOWN_TYPE = 2'd3
  } verdict_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [7:0]  type_byte;
    verdict_t    verdict;
    logic [6:0]  frame_length;
    logic [31:0] record_id;
    logic [7:0]  acked_command;
    logic [31:0] ack_parameter;
    logic [15:0] computed_crc;
    logic [15:0] received_crc;
  } out_t;

  // Input stage contents handed to the frame checker
  typedef struct packed {
    logic valid;
    in_t  item;
  } stage_t;

  // Frame size for a type code, zero for an unknown type
  function automatic logic [SZ_W-1:0] frame_size(input logic [7:0] t);
    logic [SZ_W-1:0] n;
    case (t)
      TYPE_CONTINUOUS: n = SIZE_CONTINUOUS;
      TYPE_TIMED:      n = SIZE_TIMED;
      TYPE_ACK:        n = SIZE_ACK;
      default:         n = SIZE_NONE;
    endcase
    return n;
  endfunction

  // One byte of CRC, MSB first, eight bit steps unrolled
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

### rtl/core/crc_checked_frame_validator.sv
// Frame validator for received radio frames.
//
// Usage: bytes of a frame enter on the in_ channel (valid/ready), one byte
// per transfer, with last_byte set on the final byte. Byte 0 selects the
// frame type and size; a CRC-16/CCITT-FALSE runs over all but the two
// trailer bytes, which hold the stored CRC low byte first.
// One result per frame leaves on the out_ channel (valid/ready): type,
// verdict, length, decoded id or acknowledged command and parameter, and
// both CRC values. Bytes without the last mark give no result.
// Throughput: one byte per cycle unless a final byte waits on a held result,
// set by the single-byte CRC update between input and result registers.
// Path: a last byte goes through the input register into the result register.
// Reset (rst_n low at a clock edge) empties both registers and returns
// the frame state to its start values; no clearing pass is needed.
// Stall: while a result waits on out_ready, non-final bytes still flow in
// and update the frame; a final byte waits in the input register, and
// in_ready drops only when that register is also full.
module crc_checked_frame_validator (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  cfv_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output cfv_pkg::out_t out_data
);
  import cfv_pkg::*;

  stage_t stage;
  out_t   result;
  logic   out_free;
  logic   advance;
  logic   load;
  logic   out_valid_r;
  out_t   out_data_r;

  // Move the held byte on unless it is a last byte facing a result not yet taken
  assign out_free = !out_valid_r || out_ready;
  assign advance  = stage.valid && (!stage.item.last_byte || out_free);
  assign load     = advance && stage.item.last_byte;

  cfv_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .advance  (advance),
    .stage    (stage)
  );

  cfv_frame_check u_frame_check (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (stage.item),
    .result  (result)
  );

  // Hold the result until the transfer completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  // A valid frame carries matching CRC values
  a_valid_crc_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.verdict == VERDICT_VALID
      |-> out_data.computed_crc == out_data.received_crc)
    else $error("valid verdict with differing CRC values");

  // Short or unknown frames report no CRC values
  a_no_crc_on_reject: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.verdict == VERDICT_TOO_SHORT ||
                  out_data.verdict == VERDICT_UNKNOWN_TYPE)
      |-> out_data.computed_crc == 16'h0 && out_data.received_crc == 16'h0)
    else $error("CRC fields set on rejected frame");

  // Identifier fields appear only on a valid verdict
  a_ids_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.verdict != VERDICT_VALID
      |-> out_data.record_id == 32'h0 && out_data.acked_command == 8'h0 &&
          out_data.ack_parameter == 32'h0)
    else $error("identifier fields set on non-valid frame");

  // A result never gets overwritten before it is taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !load)
    else $error("result register loaded while stalled");

  // Every result counts at least the byte that carried the mark
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> result.frame_length != 7'd0 || BUFFER_BYTES >= 128)
    else $error("zero frame length on result");
`endif

endmodule

### rtl/core/cfv_in_stage.sv
// Input register stage of the frame validator.
module cfv_in_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  cfv_pkg::in_t  in_data,
  input  logic          advance,
  output cfv_pkg::stage_t stage
);
  import cfv_pkg::*;

  logic valid_r;
  in_t  item_r;

  // Take a new transfer when empty or when the held byte moves on
  assign in_ready = !valid_r || advance;

  // Hold the valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // Capture the payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

  assign stage.valid = valid_r;
  assign stage.item  = item_r;

endmodule

### rtl/core/cfv_frame_check.sv
// Frame state, CRC update and verdict logic of the frame validator.
module cfv_frame_check (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          advance,
  input  cfv_pkg::in_t  item,
  output cfv_pkg::out_t result
);
  import cfv_pkg::*;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [7:0]       type_r, type_nxt;
  logic [15:0]      trl_r, trl_nxt;
  logic [31:0]      id_r, id_nxt;
  logic [7:0]       acmd_r, acmd_nxt;
  logic [31:0]      apar_r, apar_nxt;

  logic [CNT_W-1:0] count_upd;
  logic [15:0]      crc_upd;
  logic [7:0]       type_upd;
  logic [15:0]      trl_upd;
  logic [31:0]      id_upd;
  logic [7:0]       acmd_upd;
  logic [31:0]      apar_upd;
  logic             in_buf;
  logic [SZ_W-1:0]  n;
  logic [SZ_W-1:0]  idx_p1, idx_p2;
  logic [CNT_W+6:0] len_ext;
  logic [7:0]       b;

  assign b = item.byte_value;

  // Fold the current byte into the frame state
  always_comb begin
    in_buf    = {1'b0, count_r} < SZ_W'(BUFFER_BYTES);
    count_upd = count_r;
    crc_upd   = crc_r;
    type_upd  = type_r;
    trl_upd   = trl_r;
    id_upd    = id_r;
    acmd_upd  = acmd_r;
    apar_upd  = apar_r;
    idx_p1    = {1'b0, count_r} + SZ_W'(1);
    idx_p2    = {1'b0, count_r} + SZ_W'(2);
    if (in_buf && count_r == '0) begin
      type_upd = b;
    end
    n = frame_size(type_upd);
    if (in_buf) begin
      if (n != SIZE_NONE) begin
        if (idx_p2 < n) begin
          crc_upd = crc16_byte(crc_r, b);
        end else if (idx_p2 == n) begin
          trl_upd[7:0] = b;
        end else if (idx_p1 == n) begin
          trl_upd[15:8] = b;
        end
      end
      for (int j = 0; j < 4; j++) begin
        if (count_r == CNT_W'(j + 1)) begin
          id_upd[8*j +: 8] = id_r[8*j +: 8] | b;
        end
        if (count_r == CNT_W'(j + 2)) begin
          apar_upd[8*j +: 8] = apar_r[8*j +: 8] | b;
        end
      end
      if (count_r == CNT_W'(1)) begin
        acmd_upd = b;
      end
      count_upd = count_r + CNT_W'(1);
    end
  end

  // Build the verdict from the updated state
  always_comb begin
    len_ext              = {7'd0, count_upd};
    result               = '0;
    result.type_byte     = type_upd;
    result.frame_length  = len_ext[6:0];
    if (n == SIZE_NONE) begin
      result.verdict = VERDICT_UNKNOWN_TYPE;
    end else if ({1'b0, count_upd} < n) begin
      result.verdict = VERDICT_TOO_SHORT;
    end else begin
      result.computed_crc = crc_upd;
      result.received_crc = trl_upd;
      if (crc_upd != trl_upd) begin
        result.verdict = VERDICT_CRC_MISMATCH;
      end else begin
        result.verdict = VERDICT_VALID;
        if (type_upd == TYPE_ACK) begin
          result.acked_command = acmd_upd;
          result.ack_parameter = apar_upd;
        end else begin
          result.record_id = id_upd;
        end
      end
    end
  end

  // Advance the state, clear it after the last byte of a frame
  always_comb begin
    count_nxt = count_r;
    crc_nxt   = crc_r;
    type_nxt  = type_r;
    trl_nxt   = trl_r;
    id_nxt    = id_r;
    acmd_nxt  = acmd_r;
    apar_nxt  = apar_r;
    if (advance) begin
      if (item.last_byte) begin
        count_nxt = '0;
        crc_nxt   = CRC_INIT;
        type_nxt  = '0;
        trl_nxt   = '0;
        id_nxt    = '0;
        acmd_nxt  = '0;
        apar_nxt  = '0;
      end else begin
        count_nxt = count_upd;
        crc_nxt   = crc_upd;
        type_nxt  = type_upd;
        trl_nxt   = trl_upd;
        id_nxt    = id_upd;
        acmd_nxt  = acmd_upd;
        apar_nxt  = apar_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      crc_r   <= CRC_INIT;
      type_r  <= '0;
      trl_r   <= '0;
      id_r    <= '0;
      acmd_r  <= '0;
      apar_r  <= '0;
    end else begin
      count_r <= count_nxt;
      crc_r   <= crc_nxt;
      type_r  <= type_nxt;
      trl_r   <= trl_nxt;
      id_r    <= id_nxt;
      acmd_r  <= acmd_nxt;
      apar_r  <= apar_nxt;
    end
  end

endmodule
